>>> design/u2u_pkg.sv
// u2u_pkg: types and constants shared by the utf-8 to utf-16 decoder
// depends on nothing
package u2u_pkg;

  localparam int UNIT_COUNT_BITS = 16;

  localparam logic [15:0] CAP_RESET = 16'd4096;
  localparam logic [15:0] SURR_HI   = 16'hD800;
  localparam logic [15:0] SURR_LO   = 16'hDC00;
  localparam logic [20:0] PAIR_BASE = 21'h10000;
  localparam logic [9:0]  SURR_TOP  = 10'h01B;
  localparam logic [2:0]  SEQ_FOUR  = 3'd4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } step_out_t;

endpackage

>>> design/u2u_if.sv
// u2u_if: valid/ready channel interfaces for bytes, results and configuration
// depends on nothing
interface u2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u2u_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_error;
  logic        last;
  modport source (output valid, output code_unit, output is_error, output last, input ready);
  modport sink (input valid, input code_unit, input is_error, input last, output ready);
endinterface

interface u2u_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_capacity;
  modport source (output valid, output unit_capacity, input ready);
  modport sink (input valid, input unit_capacity, output ready);
endinterface

>>> design/utf8_to_utf16_decoder_unit.sv
// utf8_to_utf16_decoder_unit: top level of the utf-8 to utf-16 decoder
// depends on u2u_pkg, u2u_if, u2u_step and u2u_res_queue
//
// usage:
//   src carries one utf-8 byte per beat; a zero byte ends the string.
//   res carries one utf-16 code unit per beat with is_error and last; a
//   four-byte value >= 0x10000 gives a surrogate pair in consecutive beats.
//   cfg writes unit_capacity (units per string, terminator included); it is
//   always ready; users write it only while the block is idle (unchecked).
// timing:
//   a byte waits in the input register, and when it fires its results go
//   into the two-entry result register that drives res. one byte per cycle
//   is taken while res keeps up.
// reset:
//   rst clears the decoder state, empties both registers, capacity is 4096.
// stall:
//   a held res beat keeps its payload; a byte waits in the input register
//   until there is room for all its results, and src drops ready only then.
module utf8_to_utf16_decoder_unit import u2u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  u2u_byte_if.sink   src,
  u2u_res_if.source  res,
  u2u_cfg_if.sink    cfg
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic [15:0] unit_capacity;
  logic        fire;
  logic [1:0]  free;
  step_out_t   step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unit_capacity <= cfg.unit_capacity;
    end
  end

  assign fire      = hold_valid && (step.cnt <= free);
  assign src.ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src.ready) begin
      hold_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      hold_byte <= src.byte_in;
    end
  end

  u2u_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .byte_in       (hold_byte),
    .unit_capacity (unit_capacity),
    .step          (step)
  );

  u2u_res_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (fire ? step.cnt : 2'd0),
    .r0       (step.r0),
    .r1       (step.r1),
    .free     (free),
    .res      (res)
  );

  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

  a_error_ends : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.is_error |-> res.last && (res.code_unit == 16'd0))
    else $error("error result not a zero last beat");

  a_hold_stable : assert property (@(posedge clk) disable iff (rst)
    hold_valid && !fire |=> hold_valid && $stable(hold_byte))
    else $error("waiting byte lost or changed");

endmodule

>>> design/u2u_step.sv
// u2u_step: decoder state and the per-byte next-state and result logic
// depends on u2u_pkg
module u2u_step import u2u_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic [15:0] unit_capacity,
  output step_out_t   step
);

  logic [20:0]                partial_code, partial_code_next;
  logic [1:0]                 bytes_pending, bytes_pending_next;
  logic [2:0]                 sequence_length, sequence_length_next;
  logic [UNIT_COUNT_BITS-1:0] units_written, units_written_next;
  logic                       skipping_to_end, skipping_to_end_next;

  always_comb begin
    logic [20:0]                pc_ext;
    logic [20:0]                pair_off;
    logic [UNIT_COUNT_BITS:0]   uw_p1;
    logic [UNIT_COUNT_BITS+1:0] uw_p3;
    logic                       fail;
    logic [1:0]                 pend_dec;

    pc_ext   = {partial_code[14:0], byte_in[5:0]};
    pair_off = pc_ext - PAIR_BASE;
    uw_p1    = {1'b0, units_written} + (UNIT_COUNT_BITS+1)'(1);
    uw_p3    = {2'b00, units_written} + (UNIT_COUNT_BITS+2)'(3);
    pend_dec = bytes_pending - 2'd1;
    fail     = 1'b0;

    partial_code_next    = partial_code;
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    units_written_next   = units_written;
    skipping_to_end_next = skipping_to_end;
    step                 = '0;

    if (skipping_to_end) begin
      if (byte_in == 8'd0) begin
        skipping_to_end_next = 1'b0;
        partial_code_next    = '0;
        bytes_pending_next   = '0;
        sequence_length_next = '0;
        units_written_next   = '0;
      end
    end else if (bytes_pending != 2'd0) begin
      if (byte_in[7:6] != 2'b10) begin
        fail = 1'b1;
      end else if (pend_dec != 2'd0) begin
        partial_code_next  = pc_ext;
        bytes_pending_next = pend_dec;
      end else if (sequence_length != SEQ_FOUR) begin
        partial_code_next    = '0;
        bytes_pending_next   = '0;
        sequence_length_next = '0;
        units_written_next   = units_written + UNIT_COUNT_BITS'(1);
        step.cnt             = 2'd1;
        step.r0              = '{code_unit: pc_ext[15:0], is_error: 1'b0, last: 1'b0};
      end else if (pc_ext[20:11] == SURR_TOP) begin
        fail = 1'b1;
      end else begin
        partial_code_next    = '0;
        bytes_pending_next   = '0;
        sequence_length_next = '0;
        if (pc_ext[20:16] != 5'd0) begin
          if (uw_p3 > {2'b00, unit_capacity}) begin
            fail = 1'b1;
          end else begin
            units_written_next = units_written + UNIT_COUNT_BITS'(2);
            step.cnt           = 2'd2;
            step.r0 = '{code_unit: SURR_HI | {6'd0, pair_off[19:10]}, is_error: 1'b0,
                        last: 1'b0};
            step.r1 = '{code_unit: SURR_LO | {6'd0, pc_ext[9:0]}, is_error: 1'b0,
                        last: 1'b0};
          end
        end
      end
    end else if (byte_in == 8'd0) begin
      partial_code_next    = '0;
      bytes_pending_next   = '0;
      sequence_length_next = '0;
      units_written_next   = '0;
      step.cnt             = 2'd1;
      step.r0              = '{code_unit: 16'd0, is_error: 1'b0, last: 1'b1};
    end else if (uw_p1 >= {1'b0, unit_capacity}) begin
      fail = 1'b1;
    end else if (!byte_in[7]) begin
      units_written_next = units_written + UNIT_COUNT_BITS'(1);
      step.cnt           = 2'd1;
      step.r0            = '{code_unit: {8'd0, byte_in}, is_error: 1'b0, last: 1'b0};
    end else if (byte_in[7:5] == 3'b110) begin
      partial_code_next    = {16'd0, byte_in[4:0]};
      bytes_pending_next   = 2'd1;
      sequence_length_next = 3'd2;
    end else if (byte_in[7:4] == 4'b1110) begin
      partial_code_next    = {17'd0, byte_in[3:0]};
      bytes_pending_next   = 2'd2;
      sequence_length_next = 3'd3;
    end else if (byte_in[7:3] == 5'b11110) begin
      partial_code_next    = {18'd0, byte_in[2:0]};
      bytes_pending_next   = 2'd3;
      sequence_length_next = SEQ_FOUR;
    end else begin
      fail = 1'b1;
    end

    if (fail) begin
      partial_code_next    = '0;
      bytes_pending_next   = '0;
      sequence_length_next = '0;
      units_written_next   = '0;
      skipping_to_end_next = (byte_in != 8'd0);
      step.cnt             = 2'd1;
      step.r0              = '{code_unit: 16'd0, is_error: 1'b1, last: 1'b1};
      step.r1              = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code    <= '0;
      bytes_pending   <= '0;
      sequence_length <= '0;
      units_written   <= '0;
      skipping_to_end <= 1'b0;
    end else if (fire) begin
      partial_code    <= partial_code_next;
      bytes_pending   <= bytes_pending_next;
      sequence_length <= sequence_length_next;
      units_written   <= units_written_next;
      skipping_to_end <= skipping_to_end_next;
    end
  end

endmodule

>>> design/u2u_res_queue.sv
// u2u_res_queue: two-entry result register, takes up to two results per cycle
// depends on u2u_pkg and u2u_res_if
module u2u_res_queue import u2u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    r0,
  input  result_t    r1,
  output logic [1:0] free,
  u2u_res_if.source  res
);

  result_t    e0, e1, e0_next, e1_next;
  logic [1:0] cnt, cnt_next;
  logic       pop;
  logic [1:0] cnt_pop;

  assign res.valid     = (cnt != 2'd0);
  assign res.code_unit = e0.code_unit;
  assign res.is_error  = e0.is_error;
  assign res.last      = e0.last;

  assign pop     = res.valid && res.ready;
  assign cnt_pop = cnt - {1'b0, pop};
  assign free    = 2'd2 - cnt_pop;

  always_comb begin
    e0_next = e0;
    e1_next = e1;
    if (pop) begin
      e0_next = e1;
    end
    case (cnt_pop)
      2'd0: begin
        if (push_cnt != 2'd0) begin
          e0_next = r0;
        end
        if (push_cnt == 2'd2) begin
          e1_next = r1;
        end
      end
      2'd1: begin
        if (push_cnt != 2'd0) begin
          e1_next = r0;
        end
      end
      default: begin
      end
    endcase
    cnt_next = cnt_pop + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    e0 <= e0_next;
    e1 <= e1_next;
  end

endmodule

>>> bench/tb.sv
// tb: self-checking bench for utf8_to_utf16_decoder_unit, byte strings in and utf-16 units out
// depends on u2u_pkg, u2u_if and the decoder rtl; predicts every unit and checks each beat
`timescale 1ns / 100ps
module tb import u2u_pkg::*;;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_BYTES = 150;

  logic clk;
  logic rst;

  u2u_byte_if byte_ch ();
  u2u_res_if  unit_ch ();
  u2u_cfg_if  cap_ch ();

  utf8_to_utf16_decoder_unit dut (
    .clk (clk),
    .rst (rst),
    .src (byte_ch),
    .res (unit_ch),
    .cfg (cap_ch)
  );

  logic [7:0] byte_q[$];
  result_t    units_due[$];
  result_t    head;
  int         fails = 0;
  int         bytes_accepted = 0;
  int         units_seen = 0;
  int         send_gap = 0;
  int         recv_hold = 0;
  int         idle_cycles = 0;
  bit         long_hold_done = 0;
  bit         calm = 0;

  // decoder state mirror
  logic [15:0] cap_reg;
  logic [20:0] acc;
  logic [1:0]  need;
  logic [2:0]  seq_len;
  logic [15:0] n_units;
  bit          dropping;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void post(logic [15:0] u, logic err, logic lst);
    result_t r;
    r.code_unit = u;
    r.is_error = err;
    r.last = lst;
    units_due.push_back(r);
  endfunction

  function automatic void clear_string();
    acc = '0;
    need = '0;
    seq_len = '0;
    n_units = '0;
  endfunction

  function automatic void put_unit(logic [15:0] u);
    post(u, 1'b0, 1'b0);
    n_units = n_units + 16'd1;
  endfunction

  function automatic void raise_error(logic [7:0] b);
    clear_string();
    dropping = (b != 8'h00);
    post(16'h0000, 1'b1, 1'b1);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [20:0] cp;
    if (dropping) begin
      if (b == 8'h00) begin
        dropping = 1'b0;
        clear_string();
      end
      return;
    end
    if (need != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        raise_error(b);
        return;
      end
      acc = {acc[14:0], b[5:0]};
      need = need - 2'd1;
      if (need != 2'd0) return;
      cp = acc;
      if (seq_len != SEQ_FOUR) begin
        acc = '0;
        seq_len = '0;
        put_unit(cp[15:0]);
        return;
      end
      if (cp[20:11] == SURR_TOP) begin
        raise_error(b);
        return;
      end
      acc = '0;
      seq_len = '0;
      if (cp >= PAIR_BASE) begin
        if ({1'b0, n_units} + 17'd3 > {1'b0, cap_reg}) begin
          raise_error(b);
          return;
        end
        cp = cp - PAIR_BASE;
        put_unit(SURR_HI | {6'd0, cp[19:10]});
        put_unit(SURR_LO | {6'd0, cp[9:0]});
      end
      return;
    end
    if (b == 8'h00) begin
      clear_string();
      post(16'h0000, 1'b0, 1'b1);
      return;
    end
    if ({1'b0, n_units} + 17'd1 >= {1'b0, cap_reg}) begin
      raise_error(b);
      return;
    end
    if (b[7] == 1'b0) begin
      put_unit({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      acc = {16'd0, b[4:0]};
      need = 2'd1;
      seq_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      acc = {17'd0, b[3:0]};
      need = 2'd2;
      seq_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      acc = {18'd0, b[2:0]};
      need = 2'd3;
      seq_len = SEQ_FOUR;
    end else begin
      raise_error(b);
    end
  endfunction

  // stimulus generation
  function automatic void push_seq(logic [20:0] cp, int len);
    case (len)
      1: byte_q.push_back({1'b0, cp[6:0]});
      2: begin
        byte_q.push_back({3'b110, cp[10:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        byte_q.push_back({4'b1110, cp[15:12]});
        byte_q.push_back({2'b10, cp[11:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        byte_q.push_back({5'b11110, cp[20:18]});
        byte_q.push_back({2'b10, cp[17:12]});
        byte_q.push_back({2'b10, cp[11:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_random_char();
    int r;
    int n;
    logic [20:0] cp;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      byte_q.push_back(8'($urandom_range(1, 127)));
    end else if (r < 45) begin
      push_seq(21'($urandom_range(0, 'h7FF)), 2);
    end else if (r < 60) begin
      push_seq(21'($urandom_range(0, 'hFFFF)), 3);
    end else if (r < 78) begin
      case ($urandom_range(0, 3))
        0: cp = 21'($urandom_range('h10000, 'h10FFFF));
        1: cp = 21'($urandom_range('hD800, 'hDFFF));
        2: cp = 21'($urandom_range(0, 'hFFFF));
        default: cp = 21'($urandom);
      endcase
      push_seq(cp, 4);
    end else if (r < 86) begin
      // sequence cut short by a byte that is not a continuation
      n = $urandom_range(2, 4);
      case (n)
        2: byte_q.push_back({3'b110, 5'($urandom)});
        3: byte_q.push_back({4'b1110, 4'($urandom)});
        default: byte_q.push_back({5'b11110, 3'($urandom)});
      endcase
      repeat ($urandom_range(0, n - 2)) byte_q.push_back({2'b10, 6'($urandom)});
      b = 8'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      if ($urandom_range(0, 3) == 0) b = 8'h00;
      byte_q.push_back(b);
    end else if (r < 93) begin
      if ($urandom_range(0, 1) == 1) byte_q.push_back(8'($urandom_range('h80, 'hBF)));
      else byte_q.push_back(8'($urandom_range('hF8, 'hFF)));
    end else begin
      byte_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void push_string();
    int chars;
    chars = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    repeat (chars) push_random_char();
    byte_q.push_back(8'h00);
  endfunction

  task automatic settle();
    int target;
    target = bytes_accepted + byte_q.size();
    do @(posedge clk); while (bytes_accepted != target || units_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_capacity(logic [15:0] v);
    @(posedge clk);
    cap_ch.valid <= 1'b1;
    cap_ch.unit_capacity <= v;
    do @(posedge clk); while (!cap_ch.ready);
    cap_reg = v;
    cap_ch.valid <= 1'b0;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.byte_in);
        bytes_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_ch.valid <= 1'b0;
        end else if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          byte_ch.valid <= 1'b1;
          byte_ch.byte_in <= byte_q.pop_front();
        end else begin
          if (byte_q.size() != 0) send_gap = gap_len() - 1;
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // unit monitor
  always @(posedge clk) begin
    if (rst) begin
      unit_ch.ready <= 1'b0;
    end else begin
      if (unit_ch.valid && unit_ch.ready) begin
        units_seen++;
        if (units_due.size() == 0) begin
          $error("unexpected beat: code_unit %h is_error %0b last %0b",
                 unit_ch.code_unit, unit_ch.is_error, unit_ch.last);
          fails++;
        end else begin
          head = units_due.pop_front();
          if (unit_ch.code_unit !== head.code_unit) begin
            $error("code_unit: expected %h, got %h", head.code_unit, unit_ch.code_unit);
            fails++;
          end
          if (unit_ch.is_error !== head.is_error) begin
            $error("is_error: expected %0b, got %0b", head.is_error, unit_ch.is_error);
            fails++;
          end
          if (unit_ch.last !== head.last) begin
            $error("last: expected %0b, got %0b", head.last, unit_ch.last);
            fails++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        unit_ch.ready <= 1'b0;
      end else if (!long_hold_done && units_seen >= 400 && byte_q.size() > 40) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        recv_hold = 300;
        unit_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        recv_hold = gap_len() - 1;
        unit_ch.ready <= 1'b0;
      end else begin
        unit_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)
        || (cap_ch.valid && cap_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL utf8_to_utf16_decoder_unit");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] cap;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.byte_in = 8'h00;
    unit_ch.ready = 1'b0;
    cap_ch.valid = 1'b0;
    cap_ch.unit_capacity = 16'd0;
    cap_reg = CAP_RESET;
    clear_string();
    dropping = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one to four byte forms, unchecked three-byte surrogate, pair, four-byte
    // value below the pair base, terminator, four-byte surrogate with
    // skipping, a bad lead, missing continuation with and without end of string
    byte_q = {byte_q, 8'h7F, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80,
              8'hF0, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00};
    byte_q = {byte_q, 8'hF0, 8'h8D, 8'hA0, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h00};
    byte_q = {byte_q, 8'hC2, 8'h41, 8'h00, 8'hC2, 8'h00};
    settle();
    // capacity refused at the lead byte, then for a surrogate pair
    set_capacity(16'd1);
    byte_q = {byte_q, 8'h41, 8'h00};
    settle();
    set_capacity(16'd3);
    byte_q = {byte_q, 8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00};
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap = 16'd65535;
        1: cap = 16'd2;
        2: cap = 16'($urandom_range(4, 12));
        3: cap = 16'd1;
        4: cap = 16'($urandom_range(13, 40));
        5: cap = CAP_RESET;
        6: cap = 16'($urandom_range(1, 65535));
        default: cap = 16'd3;
      endcase
      set_capacity(cap);
      calm = (p == 5);
      while (byte_q.size() < PHASE_BYTES) push_string();
      settle();
    end

    repeat (10) @(posedge clk);
    if (units_due.size() != 0) begin
      $error("%0d expected units never arrived", units_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS utf8_to_utf16_decoder_unit");
    end else begin
      $display("FAIL utf8_to_utf16_decoder_unit");
    end
    $finish;
  end

endmodule

>>> utf8_to_utf16_decoder_unit.f
design/u2u_pkg.sv
design/u2u_if.sv
design/u2u_step.sv
design/u2u_res_queue.sv
design/utf8_to_utf16_decoder_unit.sv
bench/tb.sv
